// ----- rtl/core/ellipse_fit_from_moments_top_defines.svh -----
// Assertion macros for the ellipse fit from moments block.
// Included by every RTL file that carries assertions; needs i_clk and i_rst_n in scope.
`ifndef ELLIPSE_FIT_FROM_MOMENTS_TOP_DEFINES_SVH
`define ELLIPSE_FIT_FROM_MOMENTS_TOP_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define EFM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define EFM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/efm_pkg.sv -----
// Shared types and constants for the ellipse fit from moments block.
// No dependencies; imported by every module of the block.
package efm_pkg;

    localparam int COORD_BITS = 10;
    localparam logic [9:0] COORD_MASK = 10'((1 << COORD_BITS) - 1);
    localparam logic [15:0] AREA_CAP = 16'hFFFF;
    localparam int QDEPTH = 2;
    localparam int QAW = $clog2(QDEPTH);

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_EMPTY   = 2'd1,
        STS_REFUSED = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        AOP_MUL  = 2'd0,
        AOP_DIV  = 2'd1,
        AOP_SQRT = 2'd2
    } t_aop;

    // moment snapshot handed from front to back
    typedef struct packed {
        logic        refused;
        logic [15:0] n;
        logic [25:0] sx;
        logic [25:0] sy;
        logic [35:0] sxx;
        logic [35:0] syy;
        logic [35:0] sxy;
    } t_snap;

    typedef struct packed {
        logic  valid;
        t_snap snap;
    } t_qhead;

    // MUL: a[53:0] * b[63:0]; DIV: a[47:0] / b[31:0]; SQRT: isqrt(a)
    typedef struct packed {
        logic          start;
        t_aop          op;
        logic [107:0]  a;
        logic [63:0]   b;
    } t_areq;

    typedef struct packed {
        logic          done;
        logic          busy;
        logic [107:0]  y;
    } t_ares;

    typedef struct packed {
        logic        [15:0] pixel_count;
        logic signed [15:0] minor_dir_y;
        logic signed [15:0] minor_dir_x;
        logic signed [15:0] major_dir_y;
        logic signed [15:0] major_dir_x;
        logic        [18:0] minor_len;
        logic        [18:0] major_len;
        logic        [17:0] centroid_y;
        logic        [17:0] centroid_x;
    } t_result;

    typedef enum logic [4:0] {
        BS_IDLE, BS_CX, BS_CY, BS_PA, BS_QA, BS_PB, BS_QB, BS_PC, BS_QC,
        BS_V1, BS_V2, BS_D, BS_LMAJ, BS_DMAJ, BS_LMIN, BS_DMIN,
        BS_DPREP, BS_DNORM, BS_DP2, BS_DQ2, BS_DSQ, BS_DX, BS_DY, BS_OUT
    } t_bstate;

endpackage

// ----- rtl/core/efm_front.sv -----
// Front end: takes requests, updates count and raw moments, emits a snapshot.
// Depends on efm_pkg.
module efm_front import efm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_cmd        i_cmd,
    input  logic [9:0]  i_pos_x,
    input  logic [9:0]  i_pos_y,
    input  logic        i_space,
    output logic        o_ready,
    output logic        o_push,
    output t_snap       o_snap
);

    logic [15:0] r_count, n_count;
    logic [25:0] r_sx, n_sx, r_sy, n_sy;
    logic [35:0] r_sxx, n_sxx, r_syy, n_syy, r_sxy, n_sxy;
    logic [9:0]  x, y;
    logic [19:0] xx, yy, xy;
    logic        refused;

    assign o_ready = i_space;
    assign o_push  = i_valid & i_space;
    assign x  = i_pos_x & COORD_MASK;
    assign y  = i_pos_y & COORD_MASK;
    assign xx = x * x;
    assign yy = y * y;
    assign xy = x * y;

    always_comb begin
        n_count = r_count;
        n_sx = r_sx;
        n_sy = r_sy;
        n_sxx = r_sxx;
        n_syy = r_syy;
        n_sxy = r_sxy;
        refused = 1'b0;
        if (o_push) begin
            case (i_cmd)
                CMD_ADD: begin
                    if (r_count >= AREA_CAP) begin
                        refused = 1'b1;
                    end else begin
                        n_count = r_count + 16'd1;
                        n_sx  = r_sx + {16'b0, x};
                        n_sy  = r_sy + {16'b0, y};
                        n_sxx = r_sxx + {16'b0, xx};
                        n_syy = r_syy + {16'b0, yy};
                        n_sxy = r_sxy + {16'b0, xy};
                    end
                end
                CMD_REMOVE: begin
                    if (r_count == 16'd0) begin
                        refused = 1'b1;
                    end else begin
                        n_count = r_count - 16'd1;
                        n_sx  = r_sx - {16'b0, x};
                        n_sy  = r_sy - {16'b0, y};
                        n_sxx = r_sxx - {16'b0, xx};
                        n_syy = r_syy - {16'b0, yy};
                        n_sxy = r_sxy - {16'b0, xy};
                    end
                end
                CMD_CLEAR: begin
                    n_count = '0;
                    n_sx = '0;
                    n_sy = '0;
                    n_sxx = '0;
                    n_syy = '0;
                    n_sxy = '0;
                end
                default: begin
                end
            endcase
        end
        o_snap.refused = refused;
        o_snap.n   = n_count;
        o_snap.sx  = n_sx;
        o_snap.sy  = n_sy;
        o_snap.sxx = n_sxx;
        o_snap.syy = n_syy;
        o_snap.sxy = n_sxy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sx <= '0;
            r_sy <= '0;
            r_sxx <= '0;
            r_syy <= '0;
            r_sxy <= '0;
        end else begin
            r_count <= n_count;
            r_sx <= n_sx;
            r_sy <= n_sy;
            r_sxx <= n_sxx;
            r_syy <= n_syy;
            r_sxy <= n_sxy;
        end
    end

endmodule

// ----- rtl/core/efm_queue.sv -----
// Short snapshot queue between front and back.
// Depends on efm_pkg.
`include "ellipse_fit_from_moments_top_defines.svh"
module efm_queue import efm_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_snap  i_snap,
    input  logic   i_pop,
    output logic   o_space,
    output t_qhead o_head
);

    t_snap           r_mem [QDEPTH];
    logic [QAW-1:0]  r_wp, n_wp, r_rp, n_rp;
    logic [QAW:0]    r_cnt, n_cnt;

    assign o_space     = (r_cnt != (QAW+1)'(QDEPTH));
    assign o_head.valid = (r_cnt != '0);
    assign o_head.snap  = r_mem[r_rp];

    always_comb begin
        n_wp = r_wp;
        n_rp = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == QAW'(QDEPTH - 1)) ? '0 : r_wp + QAW'(1);
        end
        if (i_pop) begin
            n_rp = (r_rp == QAW'(QDEPTH - 1)) ? '0 : r_rp + QAW'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + (QAW+1)'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - (QAW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_snap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            r_wp <= n_wp;
            r_rp <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    `EFM_ASSERT_NOW(a_q_no_overflow, i_push, r_cnt != (QAW+1)'(QDEPTH), "queue push when full")
    `EFM_ASSERT_NOW(a_q_no_underflow, i_pop, r_cnt != '0, "queue pop when empty")

endmodule

// ----- rtl/core/efm_arith.sv -----
// Shared bit-serial arithmetic unit: multiply (16 bits/cycle), divide and square root
// (one result bit per cycle). Depends on efm_pkg.
`include "ellipse_fit_from_moments_top_defines.svh"
module efm_arith import efm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_areq i_req,
    output t_ares o_res
);

    logic          r_busy, n_busy, r_done, n_done;
    logic [5:0]    r_cnt, n_cnt;
    t_aop          r_op, n_op;
    logic [107:0]  r_acc, n_acc, r_x, n_x;
    logic [53:0]   r_a, n_a, r_q, n_q;
    logic [54:0]   r_rem, n_rem;
    logic [69:0]   prod;
    logic [32:0]   dtrial, ddvs;
    logic [56:0]   strem, stry;

    assign prod   = r_a * r_x[63:48];
    assign dtrial = {r_rem[31:0], r_x[47]};
    assign ddvs   = {1'b0, r_a[31:0]};
    assign strem  = {r_rem, r_x[107:106]};
    assign stry   = {1'b0, r_q, 2'b01};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt = r_cnt;
        n_op = r_op;
        n_acc = r_acc;
        n_x = r_x;
        n_a = r_a;
        n_q = r_q;
        n_rem = r_rem;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_op = i_req.op;
            n_acc = '0;
            n_q = '0;
            n_rem = '0;
            case (i_req.op)
                AOP_MUL: begin
                    n_cnt = 6'd4;
                    n_a = i_req.a[53:0];
                    n_x = {44'b0, i_req.b};
                end
                AOP_DIV: begin
                    n_cnt = 6'd48;
                    n_a = {22'b0, i_req.b[31:0]};
                    n_x = {60'b0, i_req.a[47:0]};
                end
                default: begin
                    n_cnt = 6'd54;
                    n_a = '0;
                    n_x = i_req.a;
                end
            endcase
        end else if (r_busy) begin
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
            case (r_op)
                AOP_MUL: begin
                    n_acc = (r_acc << 16) + 108'(prod);
                    n_x = r_x << 16;
                end
                AOP_DIV: begin
                    n_x = r_x << 1;
                    if (dtrial >= ddvs) begin
                        n_rem = 55'(dtrial - ddvs);
                        n_q = {r_q[52:0], 1'b1};
                    end else begin
                        n_rem = 55'(dtrial);
                        n_q = {r_q[52:0], 1'b0};
                    end
                end
                default: begin
                    n_x = r_x << 2;
                    if (strem >= stry) begin
                        n_rem = 55'(strem - stry);
                        n_q = {r_q[52:0], 1'b1};
                    end else begin
                        n_rem = 55'(strem);
                        n_q = {r_q[52:0], 1'b0};
                    end
                end
            endcase
        end
    end

    always_comb begin
        o_res.done = r_done;
        o_res.busy = r_busy;
        case (r_op)
            AOP_MUL: o_res.y = r_acc;
            AOP_DIV: o_res.y = {60'b0, r_q[47:0]};
            default: o_res.y = {54'b0, r_q};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
            r_op <= AOP_MUL;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt <= n_cnt;
            r_op <= n_op;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_x <= n_x;
        r_a <= n_a;
        r_q <= n_q;
        r_rem <= n_rem;
    end

    `EFM_ASSERT_NOW(a_ar_start_idle, i_req.start, !r_busy, "arith start while busy")

endmodule

// ----- rtl/core/efm_back.sv -----
// Back end: sequencer that turns one moment snapshot into the ellipse result.
// Depends on efm_pkg and efm_arith.
`include "ellipse_fit_from_moments_top_defines.svh"
module efm_back import efm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_qhead  i_head,
    output logic    o_pop,
    output logic    o_m_valid,
    input  logic    i_m_ready,
    output t_result o_m_res,
    output t_status o_m_status
);

    t_areq   req;
    t_ares   ares;
    t_bstate r_state, n_state;

    logic        r_issued, n_issued, r_out_valid, n_out_valid;
    t_snap       r_snap, n_snap;
    logic [51:0] r_p, n_p, r_a, n_a, r_b, n_b, r_cm, n_cm;
    logic        r_cneg, n_cneg, r_pneg, n_pneg, r_second, n_second;
    logic [107:0] r_v, n_v;
    logic [54:0] r_lmax, n_lmax, r_lmin, n_lmin, r_pm, n_pm, r_qm, n_qm;
    logic [31:0] r_nrm, n_nrm;
    logic [17:0] r_cx, n_cx, r_cy, n_cy;
    logic [18:0] r_maj, n_maj, r_min, n_min;
    logic [15:0] r_mjx, n_mjx, r_mjy, n_mjy, r_mnx, n_mnx, r_mny, n_mny;
    t_result     r_out, n_out;
    t_status     r_out_sts, n_out_sts;

    logic [51:0] y52, dab;
    logic [52:0] sab, a2, cm2;
    logic [53:0] dres;
    logic [54:0] lam, pmw;
    logic        negw;
    logic [15:0] mag;
    logic [45:0] dvd_x, dvd_y;

    efm_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_res   (ares)
    );

    function automatic logic [17:0] sat18(logic [47:0] v);
        return (v > 48'h3FFFF) ? 18'h3FFFF : v[17:0];
    endfunction

    function automatic logic [18:0] sat19(logic [47:0] v);
        return (v > 48'h7FFFF) ? 19'h7FFFF : v[18:0];
    endfunction

    assign y52   = ares.y[51:0];
    assign dres  = ares.y[53:0];
    assign dab   = (r_a > r_b) ? r_a - r_b : r_b - r_a;
    assign sab   = {1'b0, r_a} + {1'b0, r_b};
    assign cm2   = {r_cm, 1'b0};
    assign a2    = {r_a, 1'b0};
    assign lam   = r_second ? r_lmax : r_lmin;
    assign negw  = {2'b0, a2} < lam;
    assign pmw   = negw ? lam - {2'b0, a2} : {2'b0, a2} - lam;
    assign mag   = ares.y[15:0];
    assign dvd_x = {1'b0, r_pm[30:0], 14'b0} + {15'b0, r_nrm[31:1]};
    assign dvd_y = {1'b0, r_qm[30:0], 14'b0} + {15'b0, r_nrm[31:1]};

    assign o_m_valid  = r_out_valid;
    assign o_m_res    = r_out;
    assign o_m_status = r_out_sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        n_issued = r_issued;
        n_out_valid = r_out_valid & ~i_m_ready;
        n_snap = r_snap;
        n_p = r_p;
        n_a = r_a;
        n_b = r_b;
        n_cm = r_cm;
        n_cneg = r_cneg;
        n_pneg = r_pneg;
        n_second = r_second;
        n_v = r_v;
        n_lmax = r_lmax;
        n_lmin = r_lmin;
        n_pm = r_pm;
        n_qm = r_qm;
        n_nrm = r_nrm;
        n_cx = r_cx;
        n_cy = r_cy;
        n_maj = r_maj;
        n_min = r_min;
        n_mjx = r_mjx;
        n_mjy = r_mjy;
        n_mnx = r_mnx;
        n_mny = r_mny;
        n_out = r_out;
        n_out_sts = r_out_sts;
        o_pop = 1'b0;
        req.start = 1'b0;
        req.op = AOP_MUL;
        req.a = '0;
        req.b = '0;

        // every arithmetic state issues once, then waits for done
        if (!(r_state inside {BS_IDLE, BS_DPREP, BS_DNORM, BS_OUT})) begin
            req.start = !r_issued;
            n_issued = 1'b1;
            if (ares.done) begin
                n_issued = 1'b0;
            end
        end

        case (r_state)
            BS_IDLE: begin
                if (i_head.valid) begin
                    o_pop = 1'b1;
                    n_snap = i_head.snap;
                    n_state = (i_head.snap.n == 16'd0) ? BS_OUT : BS_CX;
                end
            end
            BS_CX: begin
                req.op = AOP_DIV;
                req.a = {74'b0, r_snap.sx, 8'b0};
                req.b = {48'b0, r_snap.n};
                if (ares.done) begin
                    n_cx = sat18(ares.y[47:0]);
                    n_state = BS_CY;
                end
            end
            BS_CY: begin
                req.op = AOP_DIV;
                req.a = {74'b0, r_snap.sy, 8'b0};
                req.b = {48'b0, r_snap.n};
                if (ares.done) begin
                    n_cy = sat18(ares.y[47:0]);
                    n_state = BS_PA;
                end
            end
            BS_PA: begin
                req.a = {92'b0, r_snap.n};
                req.b = {28'b0, r_snap.sxx};
                if (ares.done) begin
                    n_p = y52;
                    n_state = BS_QA;
                end
            end
            BS_QA: begin
                req.a = {82'b0, r_snap.sx};
                req.b = {38'b0, r_snap.sx};
                if (ares.done) begin
                    n_a = (r_p > y52) ? r_p - y52 : '0;
                    n_state = BS_PB;
                end
            end
            BS_PB: begin
                req.a = {92'b0, r_snap.n};
                req.b = {28'b0, r_snap.syy};
                if (ares.done) begin
                    n_p = y52;
                    n_state = BS_QB;
                end
            end
            BS_QB: begin
                req.a = {82'b0, r_snap.sy};
                req.b = {38'b0, r_snap.sy};
                if (ares.done) begin
                    n_b = (r_p > y52) ? r_p - y52 : '0;
                    n_state = BS_PC;
                end
            end
            BS_PC: begin
                req.a = {92'b0, r_snap.n};
                req.b = {28'b0, r_snap.sxy};
                if (ares.done) begin
                    n_p = y52;
                    n_state = BS_QC;
                end
            end
            BS_QC: begin
                req.a = {82'b0, r_snap.sx};
                req.b = {38'b0, r_snap.sy};
                if (ares.done) begin
                    n_cneg = r_p < y52;
                    n_cm = (r_p < y52) ? y52 - r_p : r_p - y52;
                    n_state = BS_V1;
                end
            end
            BS_V1: begin
                req.a = {56'b0, dab};
                req.b = {12'b0, dab};
                if (ares.done) begin
                    n_v = ares.y;
                    n_state = BS_V2;
                end
            end
            BS_V2: begin
                req.a = {55'b0, cm2};
                req.b = {11'b0, cm2};
                if (ares.done) begin
                    n_v = r_v + ares.y;
                    n_state = BS_D;
                end
            end
            BS_D: begin
                req.op = AOP_SQRT;
                req.a = r_v;
                if (ares.done) begin
                    n_lmax = {2'b0, sab} + {1'b0, dres};
                    n_lmin = ({1'b0, sab} > dres) ? 55'({1'b0, sab} - dres) : '0;
                    n_state = BS_LMAJ;
                end
            end
            BS_LMAJ: begin
                req.op = AOP_SQRT;
                req.a = {36'b0, r_lmax, 17'b0};
                if (ares.done) begin
                    n_v = ares.y;
                    n_state = BS_DMAJ;
                end
            end
            BS_DMAJ: begin
                req.op = AOP_DIV;
                req.a = {72'b0, r_v[35:0]};
                req.b = {48'b0, r_snap.n};
                if (ares.done) begin
                    n_maj = sat19(ares.y[47:0]);
                    n_state = BS_LMIN;
                end
            end
            BS_LMIN: begin
                req.op = AOP_SQRT;
                req.a = {36'b0, r_lmin, 17'b0};
                if (ares.done) begin
                    n_v = ares.y;
                    n_state = BS_DMIN;
                end
            end
            BS_DMIN: begin
                req.op = AOP_DIV;
                req.a = {72'b0, r_v[35:0]};
                req.b = {48'b0, r_snap.n};
                if (ares.done) begin
                    n_min = sat19(ares.y[47:0]);
                    if (r_cm == '0) begin
                        // axis-aligned: pick coordinate axes
                        n_mjx = (r_b <= r_a) ? 16'd16384 : 16'd0;
                        n_mjy = (r_b <= r_a) ? 16'd0 : 16'd16384;
                        n_mnx = (r_b >= r_a) ? 16'd16384 : 16'd0;
                        n_mny = (r_b >= r_a) ? 16'd0 : 16'd16384;
                        n_state = BS_OUT;
                    end else begin
                        n_second = 1'b0;
                        n_state = BS_DPREP;
                    end
                end
            end
            BS_DPREP: begin
                // major axis uses the smaller eigenvalue, minor the larger
                n_pm = pmw;
                n_pneg = negw ^ r_cneg;
                n_qm = {2'b0, cm2};
                n_state = BS_DNORM;
            end
            BS_DNORM: begin
                if ((r_pm[54:31] | r_qm[54:31]) != '0) begin
                    n_pm = r_pm >> 1;
                    n_qm = r_qm >> 1;
                end else begin
                    n_state = BS_DP2;
                end
            end
            BS_DP2: begin
                req.a = {53'b0, r_pm};
                req.b = {9'b0, r_pm};
                if (ares.done) begin
                    n_v = ares.y;
                    n_state = BS_DQ2;
                end
            end
            BS_DQ2: begin
                req.a = {53'b0, r_qm};
                req.b = {9'b0, r_qm};
                if (ares.done) begin
                    n_v = r_v + ares.y;
                    n_state = BS_DSQ;
                end
            end
            BS_DSQ: begin
                req.op = AOP_SQRT;
                req.a = r_v;
                if (ares.done) begin
                    n_nrm = (ares.y[31:0] == '0) ? 32'd1 : ares.y[31:0];
                    n_state = BS_DX;
                end
            end
            BS_DX: begin
                req.op = AOP_DIV;
                req.a = {62'b0, dvd_x};
                req.b = {32'b0, r_nrm};
                if (ares.done) begin
                    if (r_second) begin
                        n_mnx = r_pneg ? 16'd0 - mag : mag;
                    end else begin
                        n_mjx = r_pneg ? 16'd0 - mag : mag;
                    end
                    n_state = BS_DY;
                end
            end
            BS_DY: begin
                req.op = AOP_DIV;
                req.a = {62'b0, dvd_y};
                req.b = {32'b0, r_nrm};
                if (ares.done) begin
                    if (r_second) begin
                        n_mny = mag;
                        n_state = BS_OUT;
                    end else begin
                        n_mjy = mag;
                        n_second = 1'b1;
                        n_state = BS_DPREP;
                    end
                end
            end
            BS_OUT: begin
                if (!r_out_valid || i_m_ready) begin
                    n_out_valid = 1'b1;
                    if (r_snap.n == 16'd0) begin
                        n_out = '0;
                        n_out_sts = r_snap.refused ? STS_REFUSED : STS_EMPTY;
                    end else begin
                        n_out.pixel_count = r_snap.n;
                        n_out.minor_dir_y = r_mny;
                        n_out.minor_dir_x = r_mnx;
                        n_out.major_dir_y = r_mjy;
                        n_out.major_dir_x = r_mjx;
                        n_out.minor_len = r_min;
                        n_out.major_len = r_maj;
                        n_out.centroid_y = r_cy;
                        n_out.centroid_x = r_cx;
                        n_out_sts = r_snap.refused ? STS_REFUSED : STS_OK;
                    end
                    n_state = BS_IDLE;
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issued <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_issued <= n_issued;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_snap <= n_snap;
        r_p <= n_p;
        r_a <= n_a;
        r_b <= n_b;
        r_cm <= n_cm;
        r_cneg <= n_cneg;
        r_pneg <= n_pneg;
        r_second <= n_second;
        r_v <= n_v;
        r_lmax <= n_lmax;
        r_lmin <= n_lmin;
        r_pm <= n_pm;
        r_qm <= n_qm;
        r_nrm <= n_nrm;
        r_cx <= n_cx;
        r_cy <= n_cy;
        r_maj <= n_maj;
        r_min <= n_min;
        r_mjx <= n_mjx;
        r_mjy <= n_mjy;
        r_mnx <= n_mnx;
        r_mny <= n_mny;
        r_out <= n_out;
        r_out_sts <= n_out_sts;
    end

    `EFM_ASSERT_NOW(a_bk_done_waiting, ares.done, r_issued, "arith done with nothing issued")
    `EFM_ASSERT_NOW(a_bk_ok_nonempty, r_out_valid && r_out_sts == STS_OK,
        r_out.pixel_count != 16'd0, "ok status on empty shape")

endmodule

// ----- rtl/core/ellipse_fit_from_moments_top.sv -----
// Top level of the ellipse fit from moments block.
// Depends on efm_pkg, efm_front, efm_queue, efm_back (and efm_arith below it).
//
//  channel  | dir | tdata (low bit up)                          | tuser
//  ---------+-----+---------------------------------------------+-------------
//  s_axis   | in  | pos_x[9:0], pos_y[19:10], zero [23:20]      | cmd [1:0]
//  m_axis   | out | centroid_x, centroid_y, major_len, minor_len,| status [1:0]
//           |     | major/minor dir x,y, pixel_count, zero pad  |
//
// Flow: the front takes a request each cycle while the two-entry snapshot
// queue has room. The back takes longer on a tilted axis than on an axis-aligned
// shape, and least on an empty shape; the bit-serial divide and square root
// in the shared arithmetic unit take most of its time.
// Reset: synchronous, active low; clears the count, moments, queue and sequencer.
// Stalls: a held result waits in the output register while the back works on the
// next snapshot; the back only stops when it has a new result and that slot is full.
module ellipse_fit_from_moments_top import efm_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [23:0]  s_axis_tdata,   // pos_x[9:0], pos_y[19:10], zero[23:20]
    input  logic [1:0]   s_axis_tuser,   // cmd[1:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [159:0] m_axis_tdata,   // centroid_x[17:0], centroid_y[35:18],
                                         // major_len[54:36], minor_len[73:55],
                                         // major_dir_x[89:74], major_dir_y[105:90],
                                         // minor_dir_x[121:106], minor_dir_y[137:122],
                                         // pixel_count[153:138], zero[159:154]
    output logic [1:0]   m_axis_tuser    // status[1:0]
);

    logic    push, space, pop;
    t_snap   snap;
    t_qhead  head;
    t_result res;
    t_status sts;

    efm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_cmd   (t_cmd'(s_axis_tuser)),
        .i_pos_x (s_axis_tdata[9:0]),
        .i_pos_y (s_axis_tdata[19:10]),
        .i_space (space),
        .o_ready (s_axis_tready),
        .o_push  (push),
        .o_snap  (snap)
    );

    efm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_snap  (snap),
        .i_pop   (pop),
        .o_space (space),
        .o_head  (head)
    );

    efm_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .o_pop      (pop),
        .o_m_valid  (m_axis_tvalid),
        .i_m_ready  (m_axis_tready),
        .o_m_res    (res),
        .o_m_status (sts)
    );

    assign m_axis_tdata = {6'b0, res};
    assign m_axis_tuser = sts;

endmodule

// ----- bench/tb_ellipse_fit_from_moments_top.sv -----
// Self-checking bench for ellipse_fit_from_moments_top: directed shapes, then random pixel sets.
// Depends on efm_pkg and the RTL; results are predicted in-bench with exact integer arithmetic.
`timescale 1ns / 1ps

module tb_ellipse_fit_from_moments_top;
    import efm_pkg::*;

    typedef struct {
        t_result res;
        t_status sts;
    } t_fit;

    typedef struct {
        logic [9:0] x;
        logic [9:0] y;
    } t_pix;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [23:0]  s_axis_tdata = '0;   // pos_x[9:0], pos_y[19:10], zero[23:20]
    logic [1:0]   s_axis_tuser = '0;   // cmd[1:0]
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [159:0] m_axis_tdata;        // result fields, centroid_x lowest, zero pad on top
    logic [1:0]   m_axis_tuser;        // status[1:0]

    // shape state mirrored from the block
    logic [15:0]  shape_n;
    logic [25:0]  shape_sx, shape_sy;
    logic [35:0]  shape_sxx, shape_syy, shape_sxy;

    t_fit         expected_fits[$];
    t_pix         live_pixels[$];      // pixels added since the last clear, less the ones removed
    int           requests_sent = 0;
    int           mismatches = 0;
    int           ready_hold = 0;      // cycles left in a result-side idle burst
    bit           no_idle = 1'b0;      // set for the last part of the run

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    ellipse_fit_from_moments_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    // ---------------- prediction ----------------

    function automatic logic [63:0] isqrt(input logic [127:0] v);
        logic [63:0]  r;
        logic [63:0]  t;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            t = r | (64'd1 << i);
            if ({64'd0, t} * {64'd0, t} <= v) r = t;
        end
        return r;
    endfunction

    // rounded unit vector in Q1.14; p carries the sign, q is nonnegative
    function automatic void unit_dir(input bit pneg, input logic [63:0] pm, input logic [63:0] qm,
                                     output logic [15:0] ox, output logic [15:0] oy);
        logic [63:0] nrm, mx, my;
        while ((pm | qm) >= 64'h8000_0000) begin
            pm = pm >> 1;
            qm = qm >> 1;
        end
        nrm = isqrt({64'd0, pm} * {64'd0, pm} + {64'd0, qm} * {64'd0, qm});
        if (nrm == 0) nrm = 1;
        mx = (pm * 16384 + nrm / 2) / nrm;
        my = (qm * 16384 + nrm / 2) / nrm;
        ox = pneg ? -mx[15:0] : mx[15:0];
        oy = my[15:0];
    endfunction

    // kernel of (tensor - lambda): ((2a - L2) * sign(c), 2|c|)
    function automatic void axis_dir(input logic [63:0] a, input logic [63:0] lam2,
                                     input bit cneg, input logic [63:0] cm,
                                     output logic [15:0] ox, output logic [15:0] oy);
        logic [63:0] a2, pm;
        bit          neg;
        a2  = a * 2;
        neg = a2 < lam2;
        pm  = neg ? lam2 - a2 : a2 - lam2;
        if (cneg) neg = !neg;
        unit_dir(neg, pm, cm * 2, ox, oy);
    endfunction

    function automatic logic [18:0] axis_len(input logic [63:0] lam2, input logic [63:0] n);
        logic [63:0] v;
        v = isqrt({64'd0, lam2} << 17) / n;
        return (v > 64'd524287) ? 19'h7FFFF : v[18:0];
    endfunction

    // apply one request to the mirrored shape and return the expected fit
    function automatic t_fit fit_ellipse(input t_cmd cmd, input logic [9:0] px,
                                         input logic [9:0] py);
        t_fit        f;
        bit          refused;
        logic [35:0] x, y;
        logic [63:0] n, a, b, cm, d, dab, sab, lmax2, lmin2, cx, cy, p, q;
        bit          cneg;
        refused = 1'b0;
        x = 36'(px & COORD_MASK);
        y = 36'(py & COORD_MASK);
        case (cmd)
            CMD_ADD: begin
                if (shape_n >= AREA_CAP) refused = 1'b1;
                else begin
                    shape_sx  = shape_sx + x[25:0];
                    shape_sy  = shape_sy + y[25:0];
                    shape_sxx = shape_sxx + x * x;
                    shape_syy = shape_syy + y * y;
                    shape_sxy = shape_sxy + x * y;
                    shape_n   = shape_n + 16'd1;
                end
            end
            CMD_REMOVE: begin
                if (shape_n == 0) refused = 1'b1;
                else begin
                    shape_sx  = shape_sx - x[25:0];
                    shape_sy  = shape_sy - y[25:0];
                    shape_sxx = shape_sxx - x * x;
                    shape_syy = shape_syy - y * y;
                    shape_sxy = shape_sxy - x * y;
                    shape_n   = shape_n - 16'd1;
                end
            end
            CMD_CLEAR: begin
                shape_n = '0; shape_sx = '0; shape_sy = '0;
                shape_sxx = '0; shape_syy = '0; shape_sxy = '0;
            end
            default: ;
        endcase

        f.res = '0;
        n = 64'(shape_n);
        if (n == 0) begin
            f.sts = refused ? STS_REFUSED : STS_EMPTY;
            return f;
        end
        cx = (64'(shape_sx) << 8) / n;
        cy = (64'(shape_sy) << 8) / n;
        f.res.centroid_x = (cx > 64'h3FFFF) ? 18'h3FFFF : cx[17:0];
        f.res.centroid_y = (cy > 64'h3FFFF) ? 18'h3FFFF : cy[17:0];

        // n-scaled central moments; negative ones come from bogus removes
        p = n * 64'(shape_sxx); q = 64'(shape_sx) * 64'(shape_sx);
        a = (p > q) ? p - q : '0;
        p = n * 64'(shape_syy); q = 64'(shape_sy) * 64'(shape_sy);
        b = (p > q) ? p - q : '0;
        p = n * 64'(shape_sxy); q = 64'(shape_sx) * 64'(shape_sy);
        cneg = p < q;
        cm = cneg ? q - p : p - q;

        dab = (a > b) ? a - b : b - a;
        d = isqrt({64'd0, dab} * {64'd0, dab} + {64'd0, cm * 2} * {64'd0, cm * 2});
        sab = a + b;
        lmax2 = sab + d;
        lmin2 = (sab > d) ? sab - d : '0;   // rounding can push it below zero

        f.res.major_len = axis_len(lmax2, n);
        f.res.minor_len = axis_len(lmin2, n);

        if (cm == 0) begin
            // axis-aligned: pick coordinate axes
            f.res.major_dir_x = (b <= a) ? 16'sd16384 : 16'sd0;
            f.res.major_dir_y = (b <= a) ? 16'sd0 : 16'sd16384;
            f.res.minor_dir_x = (b >= a) ? 16'sd16384 : 16'sd0;
            f.res.minor_dir_y = (b >= a) ? 16'sd0 : 16'sd16384;
        end else begin
            axis_dir(a, lmin2, cneg, cm, f.res.major_dir_x, f.res.major_dir_y);
            axis_dir(a, lmax2, cneg, cm, f.res.minor_dir_x, f.res.minor_dir_y);
        end
        f.res.pixel_count = shape_n;
        f.sts = refused ? STS_REFUSED : STS_OK;
        return f;
    endfunction

    // ---------------- request side ----------------

    task automatic idle_burst();
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge i_clk);
    endtask

    task automatic send_request(input t_cmd cmd, input logic [9:0] px, input logic [9:0] py);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {4'd0, py, px};
        do @(posedge i_clk); while (!s_axis_tready);
        expected_fits.push_back(fit_ellipse(cmd, px, py));
        requests_sent++;
        case (cmd)
            CMD_ADD:   live_pixels.push_back('{px, py});
            CMD_CLEAR: live_pixels.delete();
            default: ;
        endcase
        if (!no_idle && $urandom_range(0, 3) == 0) idle_burst();
    endtask

    // hold off until every outstanding fit has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_fits.size() != 0);
    endtask

    // remove a pixel that is really in the shape
    task automatic remove_live_pixel();
        int   k;
        t_pix pv;
        k  = $urandom_range(0, live_pixels.size() - 1);
        pv = live_pixels[k];
        live_pixels.delete(k);
        send_request(CMD_REMOVE, pv.x, pv.y);
    endtask

    // ---------------- directed tests ----------------

    task automatic test_empty_shape();
        send_request(CMD_REMOVE, 10'd3, 10'd7);    // remove at zero area is refused
        send_request(CMD_CLEAR, 10'h3FF, 10'h3FF);
        send_request(CMD_NOP, 10'd0, 10'd0);
    endtask

    task automatic test_coordinate_extremes();
        send_request(CMD_ADD, 10'd0, 10'd0);        // single pixel, zero tensor
        send_request(CMD_ADD, 10'h3FF, 10'h3FF);
        send_request(CMD_ADD, 10'h3FF, 10'd0);
        send_request(CMD_ADD, 10'd0, 10'h3FF);      // square: a == b, c == 0
        send_request(CMD_NOP, 10'h155, 10'h2AA);
        send_request(CMD_REMOVE, 10'h3FF, 10'd0);
        send_request(CMD_CLEAR, 10'd0, 10'd0);
    endtask

    task automatic test_axis_aligned();
        for (int i = 0; i < 4; i++) send_request(CMD_ADD, 10'(100 + 10 * i), 10'd50);
        send_request(CMD_CLEAR, 10'd0, 10'd0);
        for (int i = 0; i < 4; i++) send_request(CMD_ADD, 10'd600, 10'(300 + 7 * i));
        send_request(CMD_CLEAR, 10'd0, 10'd0);
    endtask

    task automatic test_tilted();
        for (int i = 0; i < 3; i++) send_request(CMD_ADD, 10'(200 + 5 * i), 10'(200 + 3 * i));
        send_request(CMD_CLEAR, 10'd0, 10'd0);
        for (int i = 0; i < 3; i++) send_request(CMD_ADD, 10'(900 - 4 * i), 10'(20 + 9 * i));
        send_request(CMD_CLEAR, 10'd0, 10'd0);
    endtask

    // remove pixels never added: moments wrap and go inconsistent
    task automatic test_bogus_remove();
        send_request(CMD_ADD, 10'd5, 10'd5);
        send_request(CMD_ADD, 10'd6, 10'd9);
        send_request(CMD_REMOVE, 10'd900, 10'd3);
        send_request(CMD_ADD, 10'd1, 10'd1000);
        send_request(CMD_CLEAR, 10'd0, 10'd0);
        drain_results();
    endtask

    // ---------------- random shapes ----------------

    task automatic test_random_shapes(input int total);
        int          cx, cy, dx, dy, npix, t, px, py, spread;
        bit          full_range;
        while (requests_sent < total) begin
            if (requests_sent > total - 150) no_idle = 1'b1;
            send_request(CMD_CLEAR, 10'($urandom), 10'($urandom));
            full_range = ($urandom_range(0, 4) == 0);
            cx = $urandom_range(0, 1023);
            cy = $urandom_range(0, 1023);
            dx = $urandom_range(0, 20) - 10;
            dy = $urandom_range(0, 20) - 10;
            spread = $urandom_range(0, 6);
            npix = $urandom_range(1, 14);
            for (int i = 0; i < npix; i++) begin
                if (full_range) begin
                    px = $urandom_range(0, 1023);
                    py = $urandom_range(0, 1023);
                end else begin
                    t  = $urandom_range(0, 16) - 8;
                    px = cx + t * dx + $urandom_range(0, spread) - spread / 2;
                    py = cy + t * dy + $urandom_range(0, spread) - spread / 2;
                    px = (px < 0) ? 0 : (px > 1023) ? 1023 : px;
                    py = (py < 0) ? 0 : (py > 1023) ? 1023 : py;
                end
                send_request(CMD_ADD, 10'(px), 10'(py));
            end
            for (int i = $urandom_range(0, 4); i > 0 && live_pixels.size() > 0; i--)
                remove_live_pixel();
            // a little noise: idle command, bogus remove, or emptying the shape entirely
            case ($urandom_range(0, 5))
                0: send_request(CMD_NOP, 10'($urandom), 10'($urandom));
                1: send_request(CMD_REMOVE, 10'($urandom), 10'($urandom));
                2: begin
                    while (live_pixels.size() > 0) remove_live_pixel();
                    send_request(CMD_REMOVE, 10'($urandom), 10'($urandom));
                end
                default: ;
            endcase
        end
    endtask

    // ---------------- result side ----------------

    // ready drops for random bursts, never in the last part of the run
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (ready_hold > 0) begin
                ready_hold--;
                if (ready_hold == 0) m_axis_tready <= 1'b1;
            end else if (!no_idle && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                ready_hold = int'($urandom_range(1, 4));
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_fit    want;
        t_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata[153:0]);
            if (expected_fits.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result: %h", m_axis_tdata);
            end else begin
                want = expected_fits.pop_front();
                if (got != want.res || m_axis_tuser != want.sts || m_axis_tdata[159:154] != 0)
                begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("fit mismatch at request %0d", requests_sent);
                        $display({"  exp c=(%0d,%0d) len=(%0d,%0d) maj=(%0d,%0d)",
                                  " min=(%0d,%0d) n=%0d s=%0d"},
                                 want.res.centroid_x, want.res.centroid_y,
                                 want.res.major_len, want.res.minor_len,
                                 want.res.major_dir_x, want.res.major_dir_y,
                                 want.res.minor_dir_x, want.res.minor_dir_y,
                                 want.res.pixel_count, want.sts);
                        $display({"  got c=(%0d,%0d) len=(%0d,%0d) maj=(%0d,%0d)",
                                  " min=(%0d,%0d) n=%0d s=%0d pad=%0h"},
                                 got.centroid_x, got.centroid_y, got.major_len,
                                 got.minor_len, got.major_dir_x, got.major_dir_y,
                                 got.minor_dir_x, got.minor_dir_y, got.pixel_count,
                                 m_axis_tuser, m_axis_tdata[159:154]);
                    end
                end
            end
        end
    end

    // ---------------- sequence ----------------

    initial begin
        shape_n = '0; shape_sx = '0; shape_sy = '0;
        shape_sxx = '0; shape_syy = '0; shape_sxy = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_shape();
        test_coordinate_extremes();
        test_axis_aligned();
        test_tilted();
        test_bogus_remove();
        test_random_shapes(1350);
        s_axis_tvalid <= 1'b0;
        while (expected_fits.size() != 0) @(posedge i_clk);
        repeat (1000) @(posedge i_clk);    // longer than one tilted-shape fit
        if (mismatches == 0 && expected_fits.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #40_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/efm_pkg.sv
rtl/core/efm_front.sv
rtl/core/efm_queue.sv
rtl/core/efm_arith.sv
rtl/core/efm_back.sv
rtl/core/ellipse_fit_from_moments_top.sv
bench/tb_ellipse_fit_from_moments_top.sv
